>>> hdl/dpps_pkg.sv
package dpps_pkg;

    localparam int PROC_SLOTS = 16;
    localparam int SLOT_W     = $clog2(PROC_SLOTS);
    localparam int PID_W      = 5;
    localparam int USAGE_W    = 16;
    localparam int DIVCNT_W   = $clog2(USAGE_W);
    localparam int NICE_W     = 6;
    localparam int BASE_W     = 6;
    localparam int RANK_W     = 18;

    localparam logic [7:0] SLICE_RESET = 8'd10;

    typedef enum logic [2:0] {
        CMD_TICK = 3'd0,
        CMD_FORK = 3'd1,
        CMD_EXIT = 3'd2,
        CMD_WAIT = 3'd3,
        CMD_NICE = 3'd4
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_SLOT  = 3'd1,
        ST_NO_CHILD = 3'd2,
        ST_BLOCKED  = 3'd3,
        ST_NO_READY = 3'd4
    } status_code_t;

    typedef enum logic [1:0] {
        MODE_READY  = 2'd0,
        MODE_RUN    = 2'd1,
        MODE_SLEEP  = 2'd2,
        MODE_ZOMBIE = 2'd3
    } mode_t;

    typedef struct packed {
        logic [2:0]        command;
        logic signed [7:0] nice_request;
        logic [7:0]        exit_status;
    } request_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [PID_W-1:0] pid_result;
        logic [7:0]       child_code;
        logic [PID_W-1:0] running_pid;
        logic             switched;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic scan_clear;
        logic div_start;
        logic div_step;
        logic scan_eval;
        logic scan_adv;
        logic commit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_resel;
        logic scan_used;
        logic scan_last;
        logic div_last;
    } dp_stat_t;

    function automatic logic [PID_W-1:0] pid_of(input logic [SLOT_W-1:0] s);
        return PID_W'(s) + PID_W'(1);
    endfunction

endpackage

>>> hdl/dpps_ctrl.sv
module dpps_ctrl
    import dpps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     done
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_CHECK  = 7'b0000100,
        S_SLOT   = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_EVAL   = 7'b0100000,
        S_COMMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                // busy stays high through the result cycle
                if (start && !done_reg)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.need_resel)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SLOT;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SLOT:
            begin
                if (stat.scan_used)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                    if (stat.scan_last)
                        state_next = S_COMMIT;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.scan_eval = 1'b1;
                cmd.scan_adv  = 1'b1;
                state_next    = stat.scan_last ? S_COMMIT : S_SLOT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // the result strobe falls in the first idle cycle after the transaction
    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE)
        else $error("result strobe outside idle");

endmodule

>>> hdl/dpps_datapath.sv
module dpps_datapath
    import dpps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  request_t   request,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    output dp_stat_t   stat,
    output result_t    result
);

    logic              used_reg [PROC_SLOTS];
    logic              used_next [PROC_SLOTS];
    mode_t             mode_reg [PROC_SLOTS];
    mode_t             mode_next [PROC_SLOTS];
    logic [PID_W-1:0]  parent_reg [PROC_SLOTS];
    logic [PID_W-1:0]  parent_next [PROC_SLOTS];
    logic [NICE_W-1:0] nice_reg [PROC_SLOTS];
    logic [NICE_W-1:0] nice_next [PROC_SLOTS];
    logic [USAGE_W-1:0] usage_reg [PROC_SLOTS];
    logic [USAGE_W-1:0] usage_next [PROC_SLOTS];
    logic [7:0]        sused_reg [PROC_SLOTS];
    logic [7:0]        sused_next [PROC_SLOTS];
    logic [7:0]        slen_reg [PROC_SLOTS];
    logic [7:0]        slen_next [PROC_SLOTS];
    logic [7:0]        code_reg [PROC_SLOTS];
    logic [7:0]        code_next [PROC_SLOTS];

    logic [SLOT_W-1:0] active_reg, active_next;
    request_t          req_reg;
    result_t           res_reg, res_next;
    logic              resel_reg, resel_next;

    // scan and divider
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [DIVCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [USAGE_W-1:0]  quo_reg, quo_next;
    logic [BASE_W:0]     rem_reg, rem_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic                found_reg, found_next;
    logic signed [RANK_W-1:0] best_rank_reg, best_rank_next;
    logic [SLOT_W-1:0]   best_reg, best_next;

    logic [SLOT_W-1:0]   cur;
    logic [7:0]          sused_inc;
    logic                free_any, has_child, zchild_any;
    logic [SLOT_W-1:0]   free_idx, zchild_idx;
    logic [PID_W-1:0]    my_pid, par_pid;
    logic [SLOT_W-1:0]   par_idx;
    logic                par_ok;
    logic [BASE_W:0]     rem_sh;
    logic signed [RANK_W-1:0] rank_now;
    logic signed [7:0]   nice_clamped;

    assign cur    = active_reg;
    assign my_pid = pid_of(cur);

    always_comb
    begin
        free_any   = 1'b0;
        free_idx   = '0;
        has_child  = 1'b0;
        zchild_any = 1'b0;
        zchild_idx = '0;
        for (int s = PROC_SLOTS - 1; s >= 0; s--)
        begin
            if (!used_reg[s])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(s);
            end
            if (SLOT_W'(s) != cur && used_reg[s] && parent_reg[s] == my_pid)
            begin
                has_child = 1'b1;
                if (mode_reg[s] == MODE_ZOMBIE)
                begin
                    zchild_any = 1'b1;
                    zchild_idx = SLOT_W'(s);
                end
            end
        end
    end

    assign par_pid = parent_reg[cur];
    assign par_idx = SLOT_W'(par_pid - PID_W'(1));
    assign par_ok  = (par_pid != '0) && (par_pid <= PID_W'(PROC_SLOTS)) && (par_idx != cur)
                     && used_reg[par_idx] && (mode_reg[par_idx] == MODE_SLEEP);

    always_comb
    begin
        if (req_reg.nice_request > 8'sd19)
            nice_clamped = 8'sd19;
        else if (req_reg.nice_request < -8'sd20)
            nice_clamped = -8'sd20;
        else
            nice_clamped = req_reg.nice_request;
    end

    assign sused_inc = (sused_reg[cur] != 8'hFF) ? sused_reg[cur] + 8'd1 : sused_reg[cur];
    assign rem_sh    = {rem_reg[BASE_W-1:0], quo_reg[USAGE_W-1]};
    assign rank_now  = RANK_W'(signed'({1'b0, base_reg})) - RANK_W'(signed'({1'b0, quo_reg}));

    always_comb
    begin
        used_next     = used_reg;
        mode_next     = mode_reg;
        parent_next   = parent_reg;
        nice_next     = nice_reg;
        usage_next    = usage_reg;
        sused_next    = sused_reg;
        slen_next     = slen_reg;
        code_next     = code_reg;
        active_next   = active_reg;
        res_next      = res_reg;
        resel_next    = resel_reg;
        idx_next      = idx_reg;
        dcnt_next     = dcnt_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        base_next     = base_reg;
        found_next    = found_reg;
        best_rank_next = best_rank_reg;
        best_next     = best_reg;

        if (cfg_write)
            slen_next[0] = cfg_data;

        if (cmd.load_in)
        begin
            res_next   = '0;
            resel_next = 1'b0;
        end

        if (cmd.exec)
        begin
            unique case (req_reg.command)
                CMD_TICK:
                begin
                    if (usage_reg[cur] != '1)
                        usage_next[cur] = usage_reg[cur] + USAGE_W'(1);
                    sused_next[cur] = sused_inc;
                    resel_next = (sused_inc >= slen_reg[cur]) || mode_reg[cur][1];
                end
                CMD_FORK:
                begin
                    if (free_any)
                    begin
                        used_next[free_idx]   = 1'b1;
                        mode_next[free_idx]   = MODE_READY;
                        parent_next[free_idx] = my_pid;
                        nice_next[free_idx]   = '0;
                        usage_next[free_idx]  = '0;
                        sused_next[free_idx]  = sused_reg[cur];
                        slen_next[free_idx]   = slen_reg[cur];
                        code_next[free_idx]   = '0;
                        res_next.pid_result   = pid_of(free_idx);
                    end
                    else
                        res_next.status = ST_NO_SLOT;
                end
                CMD_EXIT:
                begin
                    mode_next[cur] = MODE_ZOMBIE;
                    code_next[cur] = req_reg.exit_status;
                    if (par_ok)
                    begin
                        mode_next[par_idx] = MODE_RUN;
                        active_next        = par_idx;
                        res_next.switched  = 1'b1;
                    end
                    else
                        resel_next = 1'b1;
                end
                CMD_WAIT:
                begin
                    if (!has_child)
                        res_next.status = ST_NO_CHILD;
                    else if (zchild_any)
                    begin
                        used_next[zchild_idx] = 1'b0;
                        res_next.pid_result   = pid_of(zchild_idx);
                        res_next.child_code   = code_reg[zchild_idx];
                    end
                    else
                    begin
                        mode_next[cur]  = MODE_SLEEP;
                        res_next.status = ST_BLOCKED;
                        resel_next      = 1'b1;
                    end
                end
                CMD_NICE:
                begin
                    nice_next[cur] = nice_clamped[NICE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.scan_clear)
        begin
            idx_next   = '0;
            found_next = 1'b0;
            best_next  = '0;
        end

        if (cmd.div_start)
        begin
            base_next = BASE_W'(7'sd20 - 7'(signed'(nice_reg[idx_reg])));
            quo_next  = usage_reg[idx_reg];
            rem_next  = '0;
            dcnt_next = '0;
        end

        // restoring division, one quotient bit per cycle
        if (cmd.div_step)
        begin
            dcnt_next = dcnt_reg + DIVCNT_W'(1);
            if (rem_sh >= {1'b0, base_reg})
            begin
                rem_next = rem_sh - {1'b0, base_reg};
                quo_next = {quo_reg[USAGE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[USAGE_W-2:0], 1'b0};
            end
        end

        if (cmd.scan_eval)
        begin
            // only the active slot can be running; it counts as ready here
            if (!mode_reg[idx_reg][1] && (!found_reg || rank_now > best_rank_reg))
            begin
                found_next     = 1'b1;
                best_rank_next = rank_now;
                best_next      = idx_reg;
            end
        end

        if (cmd.scan_adv)
            idx_next = idx_reg + SLOT_W'(1);

        if (cmd.commit)
        begin
            if (!mode_reg[cur][1])
                mode_next[cur] = MODE_READY;
            if (!found_reg)
                res_next.status = ST_NO_READY;
            else
            begin
                sused_next[best_reg] = '0;
                mode_next[best_reg]  = MODE_RUN;
                if (best_reg != cur)
                begin
                    active_next       = best_reg;
                    res_next.switched = 1'b1;
                end
            end
        end

        res_next.running_pid = pid_of(active_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PROC_SLOTS; s++)
            begin
                used_reg[s]   <= (s == 0);
                mode_reg[s]   <= (s == 0) ? MODE_RUN : MODE_READY;
                parent_reg[s] <= (s == 0) ? PID_W'(1) : '0;
                nice_reg[s]   <= '0;
                usage_reg[s]  <= '0;
                sused_reg[s]  <= '0;
                slen_reg[s]   <= (s == 0) ? SLICE_RESET : '0;
                code_reg[s]   <= '0;
            end
            active_reg <= '0;
            resel_reg  <= 1'b0;
            idx_reg    <= '0;
            dcnt_reg   <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            used_reg   <= used_next;
            mode_reg   <= mode_next;
            parent_reg <= parent_next;
            nice_reg   <= nice_next;
            usage_reg  <= usage_next;
            sused_reg  <= sused_next;
            slen_reg   <= slen_next;
            code_reg   <= code_next;
            active_reg <= active_next;
            resel_reg  <= resel_next;
            idx_reg    <= idx_next;
            dcnt_reg   <= dcnt_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            req_reg <= request;
        res_reg       <= res_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        base_reg      <= base_next;
        best_rank_reg <= best_rank_next;
        best_reg      <= best_next;
    end

    assign stat.need_resel = resel_reg;
    assign stat.scan_used  = used_reg[idx_reg];
    assign stat.scan_last  = (idx_reg == SLOT_W'(PROC_SLOTS - 1));
    assign stat.div_last   = (dcnt_reg == DIVCNT_W'(USAGE_W - 1));
    assign result          = res_reg;

    a_active_used: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg[active_reg])
        else $error("active slot is not in use");

    a_div_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (base_reg != '0) && (base_reg <= BASE_W'(40)))
        else $error("divisor out of range");

    a_commit_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && found_reg && best_reg != active_reg) |=> res_reg.switched)
        else $error("switch not reported");

endmodule

>>> hdl/dynamic_priority_process_scheduler_unit.sv
// Nice-based dynamic priority scheduler over a 16-slot process table. Pulse
// start with a request while busy is low; exactly one result follows, shown
// on result for one cycle with done high. The receiver cannot stall, so
// sample result whenever done is high. Simple commands (fork, nice, a tick
// that leaves the slice running, wait that reaps or finds no child, exit
// that wakes its parent) pass only through the execute and check states. A
// reselection then scans every slot and runs a restoring divide of usage by
// (20 - nice), one quotient bit per cycle, for each used slot. The slice
// length of slot zero is written through cfg_data while the block is idle;
// busy holds cfg_ready low.
module dynamic_priority_process_scheduler_unit
    import dpps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  request_t   request,
    output logic       done,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    logic     busy_int;

    dpps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (dp_stat),
        .cmd   (dp_cmd),
        .busy  (busy_int),
        .done  (done)
    );

    dpps_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .request   (request),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .stat      (dp_stat),
        .result    (result)
    );

    assign busy      = busy_int;
    // configuration transactions only land between commands
    assign cfg_ready = !busy_int;

endmodule
